>>> hdl/assert_macros.svh
// Assertion macros for the RTL of the filter table (included by ipmf_ctrl).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset.
`define AST_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/ipmf_pkg.sv
// Package with the shared types and codes of the masked IPv4 filter table.
package ipmf_pkg;

    localparam int ADDR_W   = 32;
    localparam int SLOT_W   = 10;
    localparam int ENTRY_W  = 2 * ADDR_W;

    localparam logic [ADDR_W-1:0] FREE_MARK = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_LOOKUP = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        STAT_DONE      = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NOT_FOUND = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              reject;
        logic [SLOT_W-1:0] slot;
    } result_t;

    // Register byte address index (paddr bit 2)
    localparam logic REG_BAN_MODE = 1'b0;

endpackage

>>> hdl/ipmf_mem.sv
// Synchronous single-port-write, single-port-read entry memory.
module ipmf_mem
    import ipmf_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [ENTRY_W-1:0] wr_data,
    input  logic               rd_en,
    input  logic [AW-1:0]      rd_addr,
    output logic [ENTRY_W-1:0] rd_data
);

    logic [ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/ipmf_ctrl.sv
// Scan sequencer: walks the entry memory, evaluates each entry, writes back.
`include "assert_macros.svh"

module ipmf_ctrl
    import ipmf_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024,
    parameter int IW          = 10,
    parameter int CW          = 11
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ban_mode,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         in_mode,
    input  logic [ADDR_W-1:0]  in_address,
    input  logic [ADDR_W-1:0]  in_mask,
    input  logic [ADDR_W-1:0]  in_value,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res,
    output logic               mem_wr_en,
    output logic [IW-1:0]      mem_wr_addr,
    output logic [ENTRY_W-1:0] mem_wr_data,
    output logic               mem_rd_en,
    output logic [IW-1:0]      mem_rd_addr,
    input  logic [ENTRY_W-1:0] mem_rd_data
);

    localparam logic [CW-1:0] CAP = CW'(MAX_ENTRIES);

    state_t            state_reg, state_next;
    logic [1:0]        mode_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [ADDR_W-1:0] mask_reg;
    logic [ADDR_W-1:0] want_reg;
    logic [CW-1:0]     used_count_reg, used_count_next;
    logic [CW-1:0]     rd_idx_reg, rd_idx_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [IW-1:0]     chk_idx_reg, chk_idx_next;
    logic              found_reg, found_next;
    logic [IW-1:0]     hit_idx_reg, hit_idx_next;

    logic [ADDR_W-1:0] ent_mask;
    logic [ADDR_W-1:0] ent_value;
    logic              ent_free;
    logic              hit;
    logic              more;
    logic              full;
    logic              do_append;

    assign ent_mask  = mem_rd_data[ENTRY_W-1:ADDR_W];
    assign ent_value = mem_rd_data[ADDR_W-1:0];
    assign ent_free  = (ent_value == FREE_MARK);
    assign more      = (rd_idx_reg < used_count_reg);
    assign full      = (used_count_reg == CAP);
    assign do_append = (mode_reg == MODE_ADD) && !found_reg && !full;

    // Per-entry verdict for the operation in progress
    always_comb
    begin
        case (mode_reg)
            MODE_LOOKUP: hit = !ent_free && ((addr_reg & ent_mask) == ent_value);
            MODE_ADD:    hit = ent_free;
            MODE_REMOVE: hit = !ent_free && (ent_mask == mask_reg) && (ent_value == want_reg);
            default:     hit = 1'b0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_mode == MODE_NONE) ? ST_FINISH : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if ((chk_valid_reg && hit) || (!chk_valid_reg && !more))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and counters
    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_FINISH);
        mem_rd_en       = (state_reg == ST_SCAN) && more;
        mem_rd_addr     = rd_idx_reg[IW-1:0];
        mem_wr_en       = 1'b0;
        mem_wr_addr     = hit_idx_reg;
        mem_wr_data     = {mask_reg, want_reg};
        used_count_next = used_count_reg;
        rd_idx_next     = rd_idx_reg;
        chk_valid_next  = 1'b0;
        chk_idx_next    = chk_idx_reg;
        found_next      = found_reg;
        hit_idx_next    = hit_idx_reg;

        res.status = STAT_DONE;
        res.reject = 1'b0;
        res.slot   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                rd_idx_next = '0;
                found_next  = 1'b0;
            end
            ST_SCAN:
            begin
                if (mem_rd_en)
                begin
                    rd_idx_next    = CW'(rd_idx_reg + 1'b1);
                    chk_valid_next = 1'b1;
                    chk_idx_next   = rd_idx_reg[IW-1:0];
                end
                if (chk_valid_reg && hit)
                begin
                    found_next     = 1'b1;
                    hit_idx_next   = chk_idx_reg;
                    chk_valid_next = 1'b0;
                end
            end
            ST_FINISH:
            begin
                case (mode_reg)
                    MODE_LOOKUP:
                    begin
                        res.reject = found_reg ? ban_mode : !ban_mode;
                        res.slot   = found_reg ? SLOT_W'(hit_idx_reg) : '0;
                    end
                    MODE_ADD:
                    begin
                        if (found_reg)
                        begin
                            res.slot  = SLOT_W'(hit_idx_reg);
                            mem_wr_en = res_ready;
                        end
                        else if (!full)
                        begin
                            res.slot    = SLOT_W'(used_count_reg);
                            mem_wr_en   = res_ready;
                            mem_wr_addr = used_count_reg[IW-1:0];
                        end
                        else
                        begin
                            res.status = STAT_FULL;
                        end
                        if (do_append && res_ready)
                        begin
                            used_count_next = CW'(used_count_reg + 1'b1);
                        end
                    end
                    MODE_REMOVE:
                    begin
                        mem_wr_data = {mask_reg, FREE_MARK};
                        if (found_reg)
                        begin
                            res.slot  = SLOT_W'(hit_idx_reg);
                            mem_wr_en = res_ready;
                        end
                        else
                        begin
                            res.status = STAT_NOT_FOUND;
                        end
                    end
                    default:
                    begin
                        res.status = STAT_DONE;
                    end
                endcase
            end
            default:
            begin
                rd_idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            used_count_reg <= '0;
            rd_idx_reg     <= '0;
            chk_valid_reg  <= 1'b0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            used_count_reg <= used_count_next;
            rd_idx_reg     <= rd_idx_next;
            chk_valid_reg  <= chk_valid_next;
            found_reg      <= found_next;
        end
    end

    // Operation payload and scan indexes
    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        hit_idx_reg <= hit_idx_next;
        if (in_valid && in_ready)
        begin
            mode_reg <= in_mode;
            addr_reg <= in_address;
            mask_reg <= in_mask;
            want_reg <= in_value & in_mask;
        end
    end

    `AST_ALWAYS(a_count_cap, used_count_reg <= CAP, "used count beyond capacity")
    `AST_NEXT(a_count_step, 1'b1, (used_count_reg == $past(used_count_reg)) || (used_count_reg == CW'($past(used_count_reg) + 1'b1)), "used count moved by more than one")
    `AST_ALWAYS(a_chk_range, !chk_valid_reg || (CW'(chk_idx_reg) < used_count_reg), "entry checked beyond used count")
    `AST_NEXT(a_wr_done, mem_wr_en, state_reg == ST_IDLE, "entry written without closing the transaction")

endmodule

>>> hdl/ip_mask_filter_table_top.sv
// Top level of the masked IPv4 filter table: stream ports, APB register, result register.
//
// Each transaction on the slave stream is one operation (lookup, add or remove), answered by
// exactly one transaction on the master stream. The filters live in one synchronous memory of
// MAX_ENTRIES words ({mask, compare}) read one entry per cycle. An operation is accepted, then
// reads each used entry in turn (stopping early when a lookup, remove or free-slot search hits),
// waits for the last read to return, closes the scan, and delivers the result, writing the entry
// back for an add or remove. The deliver step stretches while the output register still holds an
// untaken result. One operation is in flight at a time; the result sits in an output register,
// so a new operation is accepted while the previous result waits on m_tready. Entries come out
// of reset undefined; only slots below the used count, all of which have been written, are ever
// read, so no clearing pass is needed. ban_mode (byte address 0, reset 1) selects whether a match
// rejects (1) or admits (0) the address; write it only while no operation is pending.
module ip_mask_filter_table_top
    import ipmf_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    // slave stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // address [31:0], filter_mask [63:32], filter_value [95:64]
    input  logic [1:0]   s_tuser,   // mode [1:0]
    // master stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // status [1:0], reject [2], slot [12:3], zero [15:13]
    // APB register port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    logic               ban_mode_reg;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               m_tvalid_reg;
    result_t            m_res_reg;

    logic               mem_wr_en;
    logic [IW-1:0]      mem_wr_addr;
    logic [ENTRY_W-1:0] mem_wr_data;
    logic               mem_rd_en;
    logic [IW-1:0]      mem_rd_addr;
    logic [ENTRY_W-1:0] mem_rd_data;

    // Register port: zero-wait, one register at byte address 0
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BAN_MODE) ? {31'd0, ban_mode_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ban_mode_reg <= 1'b1;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_BAN_MODE))
        begin
            ban_mode_reg <= pwdata[0];
        end
    end

    // Result register: load when empty or when the held result is taken
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'd0, m_res_reg.slot, m_res_reg.reject, m_res_reg.status};

    ipmf_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .IW          (IW),
        .CW          (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .ban_mode    (ban_mode_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_mode     (s_tuser),
        .in_address  (s_tdata[31:0]),
        .in_mask     (s_tdata[63:32]),
        .in_value    (s_tdata[95:64]),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    ipmf_mem #(
        .DEPTH (MAX_ENTRIES),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

>>> test/tb.sv
// Self-checking testbench for the masked IPv4 filter table.
`timescale 1ns / 100ps

module tb
    import ipmf_pkg::*;
();

    localparam int          TABLE_DEPTH   = 1024;
    localparam int          SMALL_FILL    = 48;     // used-count ceiling while running random traffic
    localparam int          RAND_PER_PHASE = 185;
    localparam int          HOLD_CYCLES   = 400;
    localparam int          STALL_LIMIT   = 20000;
    localparam int          BAN_CLEAR_ROW = 18;     // directed rows from here on run with ban_mode 0
    localparam logic [31:0] ONES          = 32'hFFFF_FFFF;

    // One directed transaction: the operation, its fields, and optionally a hand-typed verdict
    typedef struct packed {
        mode_t       op;
        logic [31:0] addr;
        logic [31:0] fmask;
        logic [31:0] fval;
        logic        typed;
        result_t     verdict;
    } step_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  s_tdata;     // address [31:0], filter_mask [63:32], filter_value [95:64]
    logic [1:0]   s_tuser;     // mode [1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [15:0]  m_tdata;     // status [1:0], reject [2], slot [12:3], zero [15:13]
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    // Shadow copy of the filter table and the ban_mode register
    logic [31:0]  tbl_mask [TABLE_DEPTH];
    logic [31:0]  tbl_cmp  [TABLE_DEPTH];
    int           used_cnt = 0;
    logic         ban_mode_q = 1'b1;

    result_t      verdict_q [$];     // verdicts still owed by the block, oldest first
    step_t        steps [$];
    int           mismatch_cnt = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           hold_reqs = 0;     // long result stalls asked for so far

    ip_mask_filter_table_top #(.MAX_ENTRIES(TABLE_DEPTH)) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_cnt++;
        $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // Apply one operation to the shadow table and return the verdict it earns.
    function automatic result_t apply_filter_op(mode_t op, logic [31:0] addr,
                                                logic [31:0] fmask, logic [31:0] fval);
        result_t     r;
        int          i;
        int          n;
        logic [31:0] want;
        r = '0;
        n = used_cnt;
        i = 0;
        case (op)
            MODE_LOOKUP:
            begin
                // first live entry whose masked address equals its compare word
                while (i < n && !(tbl_cmp[i] != FREE_MARK && (addr & tbl_mask[i]) == tbl_cmp[i]))
                    i++;
                if (i < n)
                begin
                    r.reject = ban_mode_q;
                    r.slot   = i[SLOT_W-1:0];
                end
                else
                    r.reject = ~ban_mode_q;
            end
            MODE_ADD:
            begin
                // reuse the lowest free slot, else append
                while (i < n && tbl_cmp[i] != FREE_MARK)
                    i++;
                if (i == n && n >= TABLE_DEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (i == n)
                        used_cnt = n + 1;
                    tbl_mask[i] = fmask;
                    tbl_cmp[i]  = fval & fmask;
                    r.slot      = i[SLOT_W-1:0];
                end
            end
            MODE_REMOVE:
            begin
                want = fval & fmask;
                while (i < n && !(tbl_cmp[i] != FREE_MARK && tbl_mask[i] == fmask
                                  && tbl_cmp[i] == want))
                    i++;
                if (i < n)
                begin
                    tbl_cmp[i] = FREE_MARK;
                    r.slot     = i[SLOT_W-1:0];
                end
                else
                    r.status = STAT_NOT_FOUND;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic bit has_free_slot();
        for (int i = 0; i < used_cnt; i++)
            if (tbl_cmp[i] == FREE_MARK)
                return 1'b1;
        return 1'b0;
    endfunction

    // Random live slot, or -1 when the table holds no live filter.
    function automatic int pick_live_slot();
        int start;
        int j;
        if (used_cnt == 0)
            return -1;
        start = $urandom_range(used_cnt - 1);
        for (int k = 0; k < used_cnt; k++)
        begin
            j = (start + k) % used_cnt;
            if (tbl_cmp[j] != FREE_MARK)
                return j;
        end
        return -1;
    endfunction

    // Whole-octet masks half the time, as real filters use; else arbitrary bits or all ones.
    function automatic logic [31:0] rand_mask();
        logic [31:0] m;
        logic [3:0]  octets;
        m = $urandom;
        octets = 4'($urandom);
        case ($urandom_range(3))
            0: ;
            1: m = ONES;
            default:
                for (int k = 0; k < 4; k++)
                    m[8*k +: 8] = {8{octets[k]}};
        endcase
        return m;
    endfunction

    function automatic void add_step(mode_t op, logic [31:0] addr, logic [31:0] fmask,
                                     logic [31:0] fval, logic typed, logic [1:0] st,
                                     logic rej, logic [SLOT_W-1:0] slot);
        step_t s;
        s.op             = op;
        s.addr           = addr;
        s.fmask          = fmask;
        s.fval           = fval;
        s.typed          = typed;
        s.verdict.status = st;
        s.verdict.reject = rej;
        s.verdict.slot   = slot;
        steps.push_back(s);
    endfunction

    // Offer one transaction, hold it until accepted, then log the verdict it must earn.
    // tvalid stays high on return so back-to-back transactions need no gap.
    task automatic send_filter_op(mode_t op, logic [31:0] addr, logic [31:0] fmask,
                                  logic [31:0] fval, logic typed, result_t typed_verdict);
        result_t want;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {fval, fmask, addr};
        do
            @(posedge clk);
        while (!s_tready);
        want = apply_filter_op(op, addr, fmask, fval);
        verdict_q.push_back(typed ? typed_verdict : want);
    endtask

    // Drop tvalid and wait until every owed verdict has come back.
    task automatic settle_results();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (verdict_q.size() != 0);
    endtask

    // Write ban_mode with the table idle, then read it back.
    task automatic write_ban_mode(logic v);
        settle_results();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {REG_BAN_MODE, 2'b00};
        pwdata  <= {31'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        ban_mode_q = v;
        // back-to-back read: psel stays high, new setup phase
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {31'b0, v})
            report_mismatch("ban_mode readback", prdata, {31'b0, v});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_random_op();
        int          pick;
        int          s;
        mode_t       op;
        logic [31:0] addr;
        logic [31:0] fmask;
        logic [31:0] fval;
        pick  = $urandom_range(99);
        addr  = $urandom;
        fval  = $urandom;
        fmask = rand_mask();
        if (pick < 5)
            op = MODE_NONE;
        else if (pick < 50)
            op = MODE_LOOKUP;
        else if (pick < 75)
            op = MODE_ADD;
        else
            op = MODE_REMOVE;
        // keep the table small so each scan stays short; turn the add into a remove
        if (op == MODE_ADD && used_cnt >= SMALL_FILL && !has_free_slot())
            op = MODE_REMOVE;
        s = pick_live_slot();
        if (s >= 0 && $urandom_range(9) < 7)
        begin
            // aim at a live filter: a hit for lookup, a real removal for remove
            if (op == MODE_LOOKUP)
                addr = tbl_cmp[s] | (addr & ~tbl_mask[s]);
            if (op == MODE_REMOVE)
            begin
                fmask = tbl_mask[s];
                fval  = tbl_cmp[s] | (fval & ~fmask);
            end
        end
        if (op == MODE_ADD && $urandom_range(19) == 0)
        begin
            // the all-ones filter stores the free marker
            fmask = ONES;
            fval  = ONES;
        end
        else if (op == MODE_ADD && s >= 0 && $urandom_range(9) == 0)
        begin
            // duplicate filter: remove must then free the lower copy first
            fmask = tbl_mask[s];
            fval  = tbl_cmp[s];
        end
        send_filter_op(op, addr, fmask, fval, 1'b0, '0);
    endtask

    // Result side: random idling plus the long hold-off, counted here.
    initial
    begin : result_sink
        int hold_left;
        int hold_done;
        hold_left = 0;
        hold_done = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = hold_reqs;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Check every result transaction against the oldest owed verdict, field by field.
    always @(posedge clk)
    begin : verdict_check
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
                report_mismatch("result with nothing pending", 32'(m_tdata), 0);
            else
            begin
                want = verdict_q.pop_front();
                if (m_tdata[1:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[1:0]), 32'(want.status));
                if (m_tdata[2] !== want.reject)
                    report_mismatch("reject", 32'(m_tdata[2]), 32'(want.reject));
                if (m_tdata[12:3] !== want.slot)
                    report_mismatch("slot", 32'(m_tdata[12:3]), 32'(want.slot));
                if (m_tdata[15:13] !== 3'b0)
                    report_mismatch("pad bits", 32'(m_tdata[15:13]), 0);
            end
        end
    end

    // End the run when no transaction moves on either stream for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : main_seq
        int live;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_LOOKUP;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        rst_n    <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n    <= 1'b1;
        @(posedge clk);

        // Directed table: empty table, free marker, first-match order, both ban settings
        add_step(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b1, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_REMOVE, 32'h0, ONES, 32'h0, 1'b1, STAT_NOT_FOUND, 1'b0, 10'd0);
        add_step(MODE_NONE, ONES, ONES, ONES, 1'b1, STAT_DONE, 1'b0, 10'd0);
        // all-ones filter lands in slot 0 but leaves it free
        add_step(MODE_ADD, ONES, ONES, ONES, 1'b1, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, ONES, 32'h0, 32'h0, 1'b1, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_REMOVE, 32'h0, ONES, ONES, 1'b1, STAT_NOT_FOUND, 1'b0, 10'd0);
        add_step(MODE_ADD, 32'h0, 32'h00FF_FFFF, 32'h1234_5678, 1'b1, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_ADD, 32'h0, 32'h0, ONES, 1'b1, STAT_DONE, 1'b0, 10'd1);
        add_step(MODE_LOOKUP, 32'hAB34_5678, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        // remove compares the value under the mask
        add_step(MODE_REMOVE, 32'h0, 32'h00FF_FFFF, 32'hFF34_5678, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, 32'hAB34_5678, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_REMOVE, 32'h0, 32'h0, 32'h0000_1234, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, ONES, 32'h0, 32'h0, 1'b1, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_ADD, 32'h0, ONES, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_ADD, 32'h0, 32'hFF00_0000, ONES, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, ONES, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        // ban_mode cleared from here: a match admits, a miss rejects
        add_step(MODE_LOOKUP, 32'h0, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_LOOKUP, 32'h1234_5678, 32'h0, 32'h0, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_REMOVE, 32'h0, 32'hFF00_0000, 32'hFF00_0000, 1'b0, STAT_DONE, 1'b0, 10'd0);
        add_step(MODE_REMOVE, 32'h0, 32'hFF00_0000, 32'hFF00_0000, 1'b1, STAT_NOT_FOUND,
                 1'b0, 10'd0);
        add_step(MODE_NONE, 32'h0, 32'h0, 32'h0, 1'b1, STAT_DONE, 1'b0, 10'd0);

        tx_idle_pct = 7;
        rx_idle_pct = 69;
        foreach (steps[k])
        begin
            if (k == BAN_CLEAR_ROW)
                write_ban_mode(1'b0);
            send_filter_op(steps[k].op, steps[k].addr, steps[k].fmask, steps[k].fval,
                           steps[k].typed, steps[k].verdict);
        end

        // Random traffic in three idling regimes, ban_mode changed between them
        for (int ph = 0; ph < 3; ph++)
        begin
            case (ph)
                0: write_ban_mode(1'b1);
                1: write_ban_mode(1'b0);
                default: write_ban_mode(1'($urandom_range(1)));
            endcase
            tx_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 69 : 0;
            rx_idle_pct = (ph == 0) ? 69 : (ph == 1) ? 7 : 0;
            for (int k = 0; k < RAND_PER_PHASE; k++)
            begin
                // long result stall while the sender keeps offering: block must back up
                if (ph == 0 && k == 60)
                    hold_reqs++;
                // hold the sender until the pipeline is empty
                if (ph == 1 && k == 100)
                    settle_results();
                send_random_op();
            end
        end

        // Hit and free one live filter, then flip ban_mode and probe once more
        live = pick_live_slot();
        if (live >= 0)
        begin
            send_filter_op(MODE_LOOKUP, tbl_cmp[live], 32'h0, 32'h0, 1'b0, '0);
            send_filter_op(MODE_REMOVE, 32'h0, tbl_mask[live], tbl_cmp[live], 1'b0, '0);
        end
        send_filter_op(MODE_ADD, 32'h0, ONES, 32'h0A00_0001, 1'b0, '0);
        write_ban_mode(~ban_mode_q);
        send_filter_op(MODE_LOOKUP, 32'h0A00_0001, 32'h0, 32'h0, 1'b0, '0);
        send_filter_op(MODE_LOOKUP, $urandom, 32'h0, 32'h0, 1'b0, '0);
        send_filter_op(MODE_REMOVE, 32'h0, rand_mask(), $urandom, 1'b0, '0);
        send_filter_op(MODE_NONE, $urandom, $urandom, $urandom, 1'b0, '0);

        // Drain, then give any stray result one full scan time to show up
        settle_results();
        repeat (TABLE_DEPTH + 8) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
